// ===== hw/rtl/shm_pkg.sv =====
// ----------------------------------------------------------------------------
// shm_pkg
// Shared types and constants for the sensor health monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package shm_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CONF_W  = 17;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned AGE_W   = 16;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned STATE_W = 3;

    localparam logic [CONF_W-1:0] CONF_ONE = 17'h10000;
    localparam logic [CNT_W-1:0]  SAT16    = 16'hFFFF;

    localparam logic [IDX_W-1:0] REG_DEGRADED = 3'd0;
    localparam logic [IDX_W-1:0] REG_STALE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FAILED   = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_RUN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_VAL_RUN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CRIT     = 3'd5;

    localparam logic [FUNC_W-1:0] FN_VALID   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INVALID = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UNAVAIL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FAILED  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_EVAL    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RESET   = 3'd5;

    localparam logic [STATE_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATE_W-1:0] ST_UNAVAIL  = 3'd1;
    localparam logic [STATE_W-1:0] ST_DEGRADED = 3'd2;
    localparam logic [STATE_W-1:0] ST_STALE    = 3'd3;
    localparam logic [STATE_W-1:0] ST_FAILED   = 3'd4;

    // product width: conf (17) * remaining age (16)
    localparam int unsigned PROD_W = CONF_W + AGE_W;

    typedef struct packed {
        logic start;
        logic [PROD_W-1:0] dividend;
        logic [AGE_W-1:0]  divisor;
    } div_req_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == SAT16) ? v : v + 1'b1;
    endfunction

    function automatic logic [TIME_W-1:0] pos_diff(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1] ? '0 : d;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/shm_divider.sv =====
// ----------------------------------------------------------------------------
// shm_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module shm_divider (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire shm_pkg::div_req_t      req,
    output logic                        done,
    output logic [shm_pkg::CONF_W-1:0]  quotient
);
    import shm_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [AGE_W:0]      rem_reg, rem_next;
    logic [AGE_W-1:0]    den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [AGE_W:0]      trial;
    logic [AGE_W+1:0]    diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[AGE_W-1:0], quo_reg[PROD_W-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = CNT_BITS'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[AGE_W+1]) begin
                rem_next = diff[AGE_W:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[CONF_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/sensor_health_monitor_core.sv =====
// ----------------------------------------------------------------------------
// sensor_health_monitor_core
// Health tracking for one sensor with age grading and hysteresis.
// ----------------------------------------------------------------------------
// A non-evaluate beat passes through the execute state and back to idle
// before the next accept. An evaluate beat that needs the freshness ratio
// runs the grade and multiply states, then the serial divider (33 quotient
// bits plus a done strobe) and the output state. Other evaluates skip the
// divider. The result waits in the output register while later beats are
// accepted. An evaluate that finishes while the previous result is still
// waiting holds in its output state, and the input stalls until the result
// side takes that beat.
`default_nettype none
module sensor_health_monitor_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [shm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [shm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [shm_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [shm_pkg::TIME_W-1:0]    s_now_ms,
    input  wire logic [shm_pkg::CONF_W-1:0]    s_sample_confidence,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [shm_pkg::STATE_W-1:0]        m_health_state,
    output logic [shm_pkg::CONF_W-1:0]         m_confidence_out,
    output logic [shm_pkg::TIME_W-1:0]         m_age_ms,
    output logic [shm_pkg::TIME_W-1:0]         m_latency_ms,
    output logic                               m_data_seen,
    output logic                               m_critical,
    output logic [shm_pkg::CNT_W-1:0]          m_failure_count,
    output logic [shm_pkg::CNT_W-1:0]          m_valid_count,
    output logic [shm_pkg::CNT_W-1:0]          m_invalid_count,
    output logic [shm_pkg::CNT_W-1:0]          m_valid_run,
    output logic [shm_pkg::CNT_W-1:0]          m_invalid_run,
    output logic                               m_recovering
);
    import shm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_GRADE = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    logic [AGE_W-1:0] deg_reg, stale_reg, fail_reg;
    logic [RUN_W-1:0] inv_lim_reg, val_lim_reg;
    logic             crit_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CONF_W-1:0] sconf_reg;

    logic [STATE_W-1:0] st_reg;
    logic absent_reg, hard_reg, seen_reg;
    logic [TIME_W-1:0] lvt_reg, gap_reg, age_reg;
    logic [CONF_W-1:0] lconf_reg, rconf_reg;
    logic [CNT_W-1:0]  cfail_reg, cgood_reg, cbad_reg, rgood_reg, rbad_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              rec_reg;

    logic        ov_reg;
    logic [STATE_W-1:0] o_st_reg;
    logic [CONF_W-1:0]  o_conf_reg;
    logic [TIME_W-1:0]  o_age_reg, o_gap_reg;
    logic               o_seen_reg, o_crit_reg, o_rec_reg;
    logic [CNT_W-1:0]   o_cf_reg, o_cg_reg, o_cb_reg, o_rg_reg, o_rb_reg;

    div_req_t          dreq;
    logic              ddone;
    logic [CONF_W-1:0] dquo;

    shm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (ddone),
        .quotient (dquo)
    );

    logic accept;
    assign s_ready = fsm_reg == S_IDLE;
    assign accept  = s_valid && s_ready;

    logic out_load;
    assign out_load = (fsm_reg == S_OUT) && (!ov_reg || m_ready);

    // grade-stage combinational values
    logic [TIME_W-1:0]  age_c;
    logic [STATE_W-1:0] target;
    logic [AGE_W-1:0]   rem_age;
    logic               withhold;

    always_comb begin
        age_c  = pos_diff(now_reg, lvt_reg);
        target = ST_OK;
        if (fail_reg != '0 && age_c >= TIME_W'(fail_reg)) target = ST_FAILED;
        else if (stale_reg != '0 && age_c >= TIME_W'(stale_reg)) target = ST_STALE;
        else if (deg_reg != '0 && age_c >= TIME_W'(deg_reg)) target = ST_DEGRADED;
        if (hard_reg) target = ST_FAILED;
        if (rbad_reg != '0 && target == ST_OK) target = ST_DEGRADED;
        withhold = target < st_reg && st_reg != ST_UNAVAIL &&
                   val_lim_reg != '0 && rgood_reg < CNT_W'(val_lim_reg);
        rem_age = stale_reg - age_c[AGE_W-1:0];
    end

    assign dreq.start    = fsm_reg == S_MUL;
    assign dreq.dividend = prod_reg;
    assign dreq.divisor  = stale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= S_IDLE;
            deg_reg <= '0; stale_reg <= '0; fail_reg <= '0;
            inv_lim_reg <= '0; val_lim_reg <= '0; crit_reg <= 1'b0;
            st_reg <= ST_UNAVAIL; absent_reg <= 1'b1; hard_reg <= 1'b0;
            seen_reg <= 1'b0; lvt_reg <= '0; gap_reg <= '0; age_reg <= '0;
            lconf_reg <= '0; rconf_reg <= '0;
            cfail_reg <= '0; cgood_reg <= '0; cbad_reg <= '0;
            rgood_reg <= '0; rbad_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            fsm_reg <= fsm_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEGRADED: deg_reg     <= cfg_data;
                    REG_STALE:    stale_reg   <= cfg_data;
                    REG_FAILED:   fail_reg    <= cfg_data;
                    REG_INV_RUN:  inv_lim_reg <= cfg_data[RUN_W-1:0];
                    REG_VAL_RUN:  val_lim_reg <= cfg_data[RUN_W-1:0];
                    REG_CRIT:     crit_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) ov_reg <= 1'b1;
            else if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (fsm_reg)
                S_EXEC: begin
                    case (func_reg)
                        FN_VALID: begin
                            absent_reg <= 1'b0; hard_reg <= 1'b0;
                            if (seen_reg) gap_reg <= pos_diff(now_reg, lvt_reg);
                            lvt_reg <= now_reg; seen_reg <= 1'b1;
                            cgood_reg <= sat_inc(cgood_reg);
                            rbad_reg <= '0; rgood_reg <= sat_inc(rgood_reg);
                            lconf_reg <= (sconf_reg > CONF_ONE) ? CONF_ONE : sconf_reg;
                        end
                        FN_INVALID: begin
                            absent_reg <= 1'b0;
                            cbad_reg <= sat_inc(cbad_reg);
                            rgood_reg <= '0;
                            rbad_reg <= sat_inc(rbad_reg);
                            if (inv_lim_reg != '0 &&
                                sat_inc(rbad_reg) >= CNT_W'(inv_lim_reg)) begin
                                hard_reg <= 1'b1;
                                if (st_reg != ST_FAILED) cfail_reg <= sat_inc(cfail_reg);
                                st_reg <= ST_FAILED;
                            end else if (st_reg == ST_OK) begin
                                st_reg <= ST_DEGRADED;
                            end
                        end
                        FN_UNAVAIL: begin
                            absent_reg <= 1'b1; hard_reg <= 1'b0; seen_reg <= 1'b0;
                            rgood_reg <= '0; rbad_reg <= '0;
                            rconf_reg <= '0; age_reg <= '0; gap_reg <= '0;
                            st_reg <= ST_UNAVAIL;
                        end
                        FN_FAILED: begin
                            absent_reg <= 1'b0; hard_reg <= 1'b1; rgood_reg <= '0;
                            if (st_reg != ST_FAILED) cfail_reg <= sat_inc(cfail_reg);
                            st_reg <= ST_FAILED;
                        end
                        FN_RESET: begin
                            st_reg <= ST_UNAVAIL; absent_reg <= 1'b1; hard_reg <= 1'b0;
                            seen_reg <= 1'b0; lvt_reg <= '0; gap_reg <= '0;
                            age_reg <= '0; lconf_reg <= '0; rconf_reg <= '0;
                            cfail_reg <= '0; cgood_reg <= '0; cbad_reg <= '0;
                            rgood_reg <= '0; rbad_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_GRADE: begin
                    rec_reg <= !absent_reg && seen_reg && withhold;
                    if (absent_reg) begin
                        st_reg <= ST_UNAVAIL; rconf_reg <= '0;
                    end else if (!seen_reg) begin
                        st_reg <= ST_FAILED; rconf_reg <= '0;
                    end else begin
                        age_reg <= age_c;
                        if (withhold) begin
                            rconf_reg <= lconf_reg >> 1;
                        end else begin
                            if (target < st_reg && st_reg != ST_UNAVAIL) hard_reg <= 1'b0;
                            if (target == ST_FAILED && st_reg != ST_FAILED)
                                cfail_reg <= sat_inc(cfail_reg);
                            if (target > st_reg) rgood_reg <= '0;
                            st_reg <= target;
                            if (target == ST_OK || target == ST_DEGRADED) begin
                                if (stale_reg == '0) rconf_reg <= lconf_reg;
                                else if (age_c >= TIME_W'(stale_reg)) rconf_reg <= '0;
                            end else begin
                                rconf_reg <= '0;
                            end
                        end
                    end
                end
                S_MUL: ;
                S_DIV: if (ddone) rconf_reg <= dquo;
                S_OUT: begin
                    if (out_load) begin
                        o_st_reg <= st_reg; o_conf_reg <= rconf_reg;
                        o_age_reg <= age_reg; o_gap_reg <= gap_reg;
                        o_seen_reg <= seen_reg; o_crit_reg <= crit_reg;
                        o_cf_reg <= cfail_reg; o_cg_reg <= cgood_reg; o_cb_reg <= cbad_reg;
                        o_rg_reg <= rgood_reg; o_rb_reg <= rbad_reg; o_rec_reg <= rec_reg;
                    end
                end
                default: ;
            endcase
        end
        if (accept) begin
            func_reg <= s_func; now_reg <= s_now_ms; sconf_reg <= s_sample_confidence;
        end
        if (fsm_reg == S_GRADE)
            prod_reg <= PROD_W'(lconf_reg) * PROD_W'(rem_age);
    end

    logic need_div;
    assign need_div = !absent_reg && seen_reg && !rec_reg &&
                      (st_reg == ST_OK || st_reg == ST_DEGRADED) &&
                      stale_reg != '0 && age_reg < TIME_W'(stale_reg);

    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            S_IDLE:  if (accept) fsm_next = S_EXEC;
            S_EXEC:  fsm_next = (func_reg == FN_EVAL) ? S_GRADE : S_IDLE;
            S_GRADE: fsm_next = S_MUL;
            S_MUL:   fsm_next = need_div ? S_DIV : S_OUT;
            S_DIV:   if (ddone) fsm_next = S_OUT;
            S_OUT:   if (out_load) fsm_next = S_IDLE;
            default: fsm_next = S_IDLE;
        endcase
    end

    assign m_valid          = ov_reg;
    assign m_health_state   = o_st_reg;
    assign m_confidence_out = o_conf_reg;
    assign m_age_ms         = o_age_reg;
    assign m_latency_ms     = o_gap_reg;
    assign m_data_seen      = o_seen_reg;
    assign m_critical       = o_crit_reg;
    assign m_failure_count  = o_cf_reg;
    assign m_valid_count    = o_cg_reg;
    assign m_invalid_count  = o_cb_reg;
    assign m_valid_run      = o_rg_reg;
    assign m_invalid_run    = o_rb_reg;
    assign m_recovering     = o_rec_reg;
endmodule
`default_nettype wire

// ===== dv/tb_sensor_health_monitor_core.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_health_monitor_core
// Self-checking bench for the sensor health monitor core. A directed list of
// events is followed by random event streams under several register
// settings. Every evaluate beat is predicted in the bench and compared field
// by field with the result channel. Both channels idle at random, and once
// the result side holds off long enough to stall the input side.
// ----------------------------------------------------------------------------
module tb_sensor_health_monitor_core;
    timeunit 1ns;
    timeprecision 1ps;
    import shm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [CONF_W-1:0]  conf;
        logic [TIME_W-1:0]  age;
        logic [TIME_W-1:0]  latency;
        logic               data_seen;
        logic               critical;
        logic [CNT_W-1:0]   fail_cnt;
        logic [CNT_W-1:0]   good_cnt;
        logic [CNT_W-1:0]   bad_cnt;
        logic [CNT_W-1:0]   good_run;
        logic [CNT_W-1:0]   bad_run;
        logic               recovering;
    } health_rpt_t;

    typedef struct {
        logic [FUNC_W-1:0]  fn;
        logic [TIME_W-1:0]  now;
        logic [CONF_W-1:0]  conf;
        bit                 has_state;
        logic [STATE_W-1:0] state;
    } event_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func = '0;
    logic [TIME_W-1:0]    s_now_ms = '0;
    logic [CONF_W-1:0]    s_sample_confidence = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    health_rpt_t          got;

    sensor_health_monitor_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_now_ms(s_now_ms), .s_sample_confidence(s_sample_confidence),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_health_state(got.state), .m_confidence_out(got.conf),
        .m_age_ms(got.age), .m_latency_ms(got.latency),
        .m_data_seen(got.data_seen), .m_critical(got.critical),
        .m_failure_count(got.fail_cnt), .m_valid_count(got.good_cnt),
        .m_invalid_count(got.bad_cnt), .m_valid_run(got.good_run),
        .m_invalid_run(got.bad_run), .m_recovering(got.recovering)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // registers as the bench sees them
    logic [15:0] lim_degraded, lim_stale, lim_failed;
    logic [7:0]  bad_to_fail, good_to_recover;
    logic        crit_cfg;

    // health state mirror
    logic [STATE_W-1:0] cur_st;
    logic               absent, hard_fail, seen;
    logic [31:0]        last_time, gap, held_age;
    logic [16:0]        last_conf, rep_conf;
    logic [15:0]        n_fail, n_good, n_bad, r_good, r_bad;

    health_rpt_t pending_rpts[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] clamp_diff(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31] ? 32'd0 : d;
    endfunction

    task automatic clear_health();
        cur_st = ST_UNAVAIL;
        absent = 1'b1; hard_fail = 1'b0; seen = 1'b0;
        last_time = '0; gap = '0; held_age = '0;
        last_conf = '0; rep_conf = '0;
        n_fail = '0; n_good = '0; n_bad = '0; r_good = '0; r_bad = '0;
    endtask

    task automatic enter_state(input logic [STATE_W-1:0] st);
        if (st == ST_FAILED && cur_st != ST_FAILED) n_fail = bump(n_fail);
        if (st > cur_st) r_good = '0;
        cur_st = st;
    endtask

    // returns 1 when improvement was withheld
    task automatic grade_health(input logic [31:0] now, output bit withheld);
        logic [31:0]        age;
        logic [STATE_W-1:0] tgt;
        logic [63:0]        prod;
        withheld = 1'b0;
        if (absent) begin
            cur_st = ST_UNAVAIL;
            rep_conf = '0;
            return;
        end
        if (!seen) begin
            cur_st = ST_FAILED;
            rep_conf = '0;
            return;
        end
        age = clamp_diff(now, last_time);
        held_age = age;
        tgt = ST_OK;
        if (lim_failed != 0 && age >= lim_failed) tgt = ST_FAILED;
        else if (lim_stale != 0 && age >= lim_stale) tgt = ST_STALE;
        else if (lim_degraded != 0 && age >= lim_degraded) tgt = ST_DEGRADED;
        if (hard_fail) tgt = ST_FAILED;
        if (r_bad != 0 && tgt == ST_OK) tgt = ST_DEGRADED;
        if (tgt < cur_st && cur_st != ST_UNAVAIL) begin
            if (good_to_recover != 0 && r_good < good_to_recover) begin
                rep_conf = last_conf >> 1;
                withheld = 1'b1;
                return;
            end
            hard_fail = 1'b0;
        end
        enter_state(tgt);
        if (cur_st == ST_OK || cur_st == ST_DEGRADED) begin
            if (lim_stale == 0) rep_conf = last_conf;
            else if (age >= lim_stale) rep_conf = '0;
            else begin
                prod = 64'(last_conf) * 64'(32'(lim_stale) - age);
                rep_conf = 17'(prod / 64'(lim_stale));
            end
        end else begin
            rep_conf = '0;
        end
    endtask

    task automatic apply_event(input logic [FUNC_W-1:0] fn, input logic [31:0] now,
                               input logic [16:0] conf, output bit emits,
                               output health_rpt_t r);
        bit wh;
        emits = 1'b0;
        r = '0;
        case (fn)
            FN_VALID: begin
                absent = 1'b0; hard_fail = 1'b0;
                if (seen) gap = clamp_diff(now, last_time);
                last_time = now; seen = 1'b1;
                n_good = bump(n_good);
                r_bad = '0; r_good = bump(r_good);
                last_conf = (conf > CONF_ONE) ? CONF_ONE : conf;
            end
            FN_INVALID: begin
                absent = 1'b0;
                n_bad = bump(n_bad);
                r_good = '0; r_bad = bump(r_bad);
                if (bad_to_fail != 0 && r_bad >= bad_to_fail) begin
                    hard_fail = 1'b1;
                    enter_state(ST_FAILED);
                end else if (cur_st == ST_OK) begin
                    enter_state(ST_DEGRADED);
                end
            end
            FN_UNAVAIL: begin
                absent = 1'b1; hard_fail = 1'b0; seen = 1'b0;
                r_good = '0; r_bad = '0;
                rep_conf = '0; held_age = '0; gap = '0;
                cur_st = ST_UNAVAIL;
            end
            FN_FAILED: begin
                absent = 1'b0; hard_fail = 1'b1; r_good = '0;
                enter_state(ST_FAILED);
            end
            FN_EVAL: begin
                grade_health(now, wh);
                emits = 1'b1;
                r = '{cur_st, rep_conf, held_age, gap, seen, crit_cfg,
                      n_fail, n_good, n_bad, r_good, r_bad, wh};
            end
            FN_RESET: clear_health();
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_DEGRADED: lim_degraded = val;
            REG_STALE:    lim_stale = val;
            REG_FAILED:   lim_failed = val;
            REG_INV_RUN:  bad_to_fail = val[7:0];
            REG_VAL_RUN:  good_to_recover = val[7:0];
            REG_CRIT:     crit_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] dg, input logic [15:0] st,
                              input logic [15:0] fl, input logic [7:0] nb,
                              input logic [7:0] ng, input logic cr);
        write_reg(REG_DEGRADED, dg);
        write_reg(REG_STALE, st);
        write_reg(REG_FAILED, fl);
        write_reg(REG_INV_RUN, {8'd0, nb});
        write_reg(REG_VAL_RUN, {8'd0, ng});
        write_reg(REG_CRIT, {15'd0, cr});
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input event_row_t row);
        int unsigned gap_cyc;
        bit          emits;
        health_rpt_t r;
        gap_cyc = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap_cyc != 0) begin
            s_valid <= 1'b0;
            repeat (gap_cyc) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= row.fn;
        s_now_ms <= row.now;
        s_sample_confidence <= row.conf;
        do @(posedge aclk); while (!s_ready);
        apply_event(row.fn, row.now, row.conf, emits, r);
        if (row.has_state && r.state !== row.state) begin
            $error("directed state: expected %0d actual %0d", row.state, r.state);
            errors++;
        end
        if (emits) pending_rpts = {pending_rpts, r};
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        wait (pending_rpts.size() == 0);
        @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic event_row_t ev(input logic [FUNC_W-1:0] fn, input logic [31:0] now,
                                      input logic [16:0] conf, input bit hs,
                                      input logic [STATE_W-1:0] st);
        event_row_t r;
        r.fn = fn; r.now = now; r.conf = conf; r.has_state = hs; r.state = st;
        return r;
    endfunction

    // random event stream with a mostly advancing sensor clock
    task automatic random_stream(input int unsigned count, input logic [15:0] step_max);
        logic [31:0]       clk_ms;
        int unsigned       pick;
        logic [FUNC_W-1:0] fn;
        logic [31:0]       now;
        logic [16:0]       conf;
        clk_ms = $urandom;
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) fn = FN_VALID;
            else if (pick < 75) fn = FN_EVAL;
            else if (pick < 88) fn = FN_INVALID;
            else if (pick < 92) fn = FN_FAILED;
            else if (pick < 95) fn = FN_UNAVAIL;
            else if (pick < 97) fn = FN_RESET;
            else fn = FUNC_W'($urandom_range(6, 7));
            if ($urandom_range(0, 19) == 0) now = $urandom;
            else begin
                clk_ms = clk_ms + $urandom_range(0, step_max);
                now = clk_ms;
                if ($urandom_range(0, 15) == 0) now = clk_ms - $urandom_range(1, 500);
            end
            conf = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            send_beat(ev(fn, now, conf, 1'b0, ST_OK));
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        health_rpt_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rpts.size() == 0) begin
                $error("result beat with no evaluate pending");
                errors++;
            end else begin
                e = pending_rpts.pop_front();
                check_field("health_state", 32'(e.state), 32'(got.state));
                check_field("confidence_out", 32'(e.conf), 32'(got.conf));
                check_field("age_ms", e.age, got.age);
                check_field("latency_ms", e.latency, got.latency);
                check_field("data_seen", 32'(e.data_seen), 32'(got.data_seen));
                check_field("critical", 32'(e.critical), 32'(got.critical));
                check_field("failure_count", 32'(e.fail_cnt), 32'(got.fail_cnt));
                check_field("valid_count", 32'(e.good_cnt), 32'(got.good_cnt));
                check_field("invalid_count", 32'(e.bad_cnt), 32'(got.bad_cnt));
                check_field("valid_run", 32'(e.good_run), 32'(got.good_run));
                check_field("invalid_run", 32'(e.bad_run), 32'(got.bad_run));
                check_field("recovering", 32'(e.recovering), 32'(got.recovering));
            end
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int unsigned wait_cyc;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end
            wait_cyc = gaps_on ? $urandom_range(0, 4) : 0;
            if (wait_cyc != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cyc) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        event_row_t rows[$];
        lim_degraded = '0; lim_stale = '0; lim_failed = '0;
        bad_to_fail = '0; good_to_recover = '0; crit_cfg = 1'b0;
        clear_health();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset values
        rows = '{
            ev(FN_EVAL, 32'd0, 17'd0, 1'b1, ST_UNAVAIL),
            ev(3'd6, 32'hFFFF_FFFF, 17'h1FFFF, 1'b0, ST_OK),
            ev(3'd7, 32'h0, 17'h0, 1'b0, ST_OK),
            ev(FN_INVALID, 32'd5, 17'd0, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd5, 17'd0, 1'b1, ST_FAILED),
            ev(FN_VALID, 32'd100, 17'h1FFFF, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd100, 17'd0, 1'b1, ST_OK),
            ev(FN_VALID, 32'd50, 17'd65536, 1'b0, ST_OK),
            ev(FN_EVAL, 32'hFFFF_FFFF, 17'd0, 1'b0, ST_OK),
            ev(FN_FAILED, 32'd60, 17'd0, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd60, 17'd0, 1'b1, ST_FAILED),
            ev(FN_UNAVAIL, 32'd70, 17'd0, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd70, 17'd0, 1'b1, ST_UNAVAIL),
            ev(FN_RESET, 32'd80, 17'd0, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd80, 17'd0, 1'b1, ST_UNAVAIL)
        };
        foreach (rows[i]) send_beat(rows[i]);
        settle();

        set_limits(16'd10, 16'd100, 16'd1000, 8'd2, 8'd3, 1'b1);
        rows = '{
            ev(FN_VALID, 32'd0, 17'd40000, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd50, 17'd0, 1'b1, ST_DEGRADED),
            ev(FN_EVAL, 32'd99, 17'd0, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd100, 17'd0, 1'b1, ST_STALE),
            ev(FN_EVAL, 32'd1000, 17'd0, 1'b1, ST_FAILED),
            ev(FN_INVALID, 32'd1001, 17'd0, 1'b0, ST_OK),
            ev(FN_INVALID, 32'd1002, 17'd0, 1'b0, ST_OK),
            ev(FN_VALID, 32'd1003, 17'd65535, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd1004, 17'd0, 1'b1, ST_FAILED),
            ev(FN_VALID, 32'd1005, 17'd65535, 1'b0, ST_OK),
            ev(FN_VALID, 32'd1006, 17'd65535, 1'b0, ST_OK),
            ev(FN_EVAL, 32'd1007, 17'd0, 1'b1, ST_OK)
        };
        foreach (rows[i]) send_beat(rows[i]);
        settle();

        set_limits(16'd40, 16'd150, 16'd600, 8'd3, 8'd2, 1'b0);
        random_stream(130, 16'd60);
        settle();

        hold_req = 1'b1;
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        random_stream(130, 16'd30000);
        settle();

        gaps_on = 1'b0;
        set_limits(16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        random_stream(120, 16'd100);
        settle();
        gaps_on = 1'b1;

        set_limits(16'($urandom_range(1, 200)), 16'($urandom_range(1, 400)),
                   16'($urandom_range(1, 2000)), 8'($urandom_range(1, 5)),
                   8'($urandom_range(0, 4)), 1'($urandom));
        random_stream(140, 16'd150);
        settle();

        set_limits(16'h5555, 16'hAAAA, 16'hC3C3, 8'hA5, 8'h5A, 1'b1);
        random_stream(130, 16'd20000);
        settle();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
